// File: sv/ifmt_pkg.sv
// Package for the integer-to-ASCII formatter.
// Holds the transfer payload types, format codes, character constants and the sequencer states.
// Depends on nothing.
package ifmt_pkg;

  localparam logic [1:0] FUNC_DEC  = 2'd0;
  localparam logic [1:0] FUNC_HEX  = 2'd1;
  localparam logic [1:0] FUNC_BIN  = 2'd2;
  localparam logic [1:0] FUNC_CHAR = 2'd3;

  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned SH_W       = 4 * BCD_DIGITS;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ALPHA = 8'h37;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_PRE0,
    ST_PREX,
    ST_SKIP,
    ST_DIGIT,
    ST_SPACE,
    ST_BIT,
    ST_CHAR
  } state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {4'd0, nib};
    end
    return CH_ALPHA + {4'd0, nib};
  endfunction

  function automatic logic [39:0] bcd_adjust(input logic [39:0] bcd);
    logic [39:0] res;
    res = bcd;
    for (int i = 0; i < 10; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

// File: sv/integer_to_ascii_formatter_core.sv
// Top level of the integer-to-ASCII formatter: a small sequencer around two shift registers.
// Uses ifmt_pkg for payload types, codes and helper functions.
//
// A value is taken when start is high and busy is low; busy then stays high until the
// final character has been sent. Characters come out one per cycle on out_data, except
// during conversion and while leading zeros are skipped, each marked by out_strobe for a
// single cycle, and the receiver cannot hold them off. The last character of a value
// carries out_data.last. Decimal first runs shift-add conversion of all 32 value bits in
// the shared 40-bit shift register, then skips leading zero digits and sends the rest.
// Hex and binary send a prefix (0x or 0b), skip leading zero nibbles up to the first
// nonzero or last nibble, then send the rest: hex one digit per nibble, binary a space
// and four bits per nibble, or a single 0 for a zero value. Char mode sends the value's
// low byte as one character. The final character appears with busy already low, when
// the next value may already be taken.
module integer_to_ascii_formatter_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ifmt_pkg::in_t  in_data,
  output logic          out_strobe,
  output ifmt_pkg::out_t out_data
);
  import ifmt_pkg::*;

  state_t      state_r, state_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [39:0] sh_r, sh_nxt;
  logic [31:0] bin_r, bin_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [3:0]  ndig_r, ndig_nxt;
  logic [1:0]  bit_r, bit_nxt;
  logic        out_strobe_r, out_strobe_nxt;
  out_t        out_data_r, out_data_nxt;
  logic [3:0]  top_nib;
  logic [39:0] sh_adj;

  assign top_nib    = sh_r[39:36];
  assign sh_adj     = bcd_adjust(sh_r);
  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    sh_r       <= sh_nxt;
    bin_r      <= bin_nxt;
    cnt_r      <= cnt_nxt;
    ndig_r     <= ndig_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    sh_nxt         = sh_r;
    bin_nxt        = bin_r;
    cnt_nxt        = cnt_r;
    ndig_nxt       = ndig_r;
    bit_nxt        = bit_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt = in_data.func;
          bin_nxt  = in_data.value;
          cnt_nxt  = '0;
          unique case (in_data.func) inside
            FUNC_DEC: begin
              sh_nxt    = '0;
              ndig_nxt  = 4'(BCD_DIGITS);
              state_nxt = ST_CONV;
            end
            FUNC_HEX, FUNC_BIN: begin
              sh_nxt    = {in_data.value, 8'd0};
              ndig_nxt  = 4'(HEX_DIGITS);
              state_nxt = ST_PRE0;
            end
            default: begin
              state_nxt = ST_CHAR;
            end
          endcase
        end
      end
      ST_CONV: begin
        sh_nxt  = {sh_adj[38:0], bin_r[31]};
        bin_nxt = {bin_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(VAL_W - 1)) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_PRE0: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{text_char: CH_ZERO, last: 1'b0};
        state_nxt      = ST_PREX;
      end
      ST_PREX: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{text_char: (func_r == FUNC_HEX) ? CH_X : CH_B, last: 1'b0};
        state_nxt      = ST_SKIP;
      end
      ST_SKIP: begin
        if (top_nib == 4'd0 && ndig_r > 4'd1) begin
          sh_nxt   = {sh_r[35:0], 4'd0};
          ndig_nxt = ndig_r - 4'd1;
        end else if (func_r == FUNC_BIN) begin
          state_nxt = ST_SPACE;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{text_char: digit_char(top_nib), last: (ndig_r == 4'd1)};
        sh_nxt         = {sh_r[35:0], 4'd0};
        ndig_nxt       = ndig_r - 4'd1;
        if (ndig_r == 4'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SPACE: begin
        out_strobe_nxt = 1'b1;
        if (bin_r == '0) begin
          out_data_nxt = '{text_char: CH_ZERO, last: 1'b1};
          state_nxt    = ST_IDLE;
        end else begin
          out_data_nxt = '{text_char: CH_SPACE, last: 1'b0};
          bit_nxt      = '0;
          state_nxt    = ST_BIT;
        end
      end
      ST_BIT: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{text_char: sh_r[39] ? CH_ONE : CH_ZERO,
                           last: (bit_r == 2'd3 && ndig_r == 4'd1)};
        sh_nxt         = {sh_r[38:0], 1'b0};
        bit_nxt        = bit_r + 2'd1;
        if (bit_r == 2'd3) begin
          ndig_nxt = ndig_r - 4'd1;
          if (ndig_r == 4'd1) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SPACE;
          end
        end
      end
      ST_CHAR: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{text_char: bin_r[7:0], last: 1'b1};
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/ifmt_checker.sv
// Port-level checker for the integer-to-ASCII formatter, bound to the top level.
// Uses ifmt_pkg for the payload types.
module ifmt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input ifmt_pkg::in_t  in_data,
  input logic           out_strobe,
  input ifmt_pkg::out_t out_data
);
  import ifmt_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an input transfer");

  a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("character sent without an item in progress");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last) |-> !busy)
    else $error("busy still high after the final character");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last) |-> busy)
    else $error("item ended without a final character");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !out_strobe)
    else $error("character sent while idle");

endmodule

bind integer_to_ascii_formatter_core ifmt_checker u_ifmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);
